// ===== hdl/lfsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsf_pkg
// Shared widths, defaults and helpers for the largest free square finder.
// ----------------------------------------------------------------------------
package lfsf_pkg;

  localparam int SIZE_W            = 11;
  localparam int POS_W             = 10;
  localparam int CHAR_W            = 8;
  localparam int OUT_DATA_W        = 32;
  localparam int MAX_COLS_DEF      = 1024;
  localparam int MAX_ROWS_DEF      = 1024;

  localparam logic [CHAR_W-1:0] FREE_CODE_RST = 8'd46;
  localparam logic [SIZE_W-1:0] SIZE_CAP      = 11'd2047;

  typedef logic [SIZE_W-1:0] size_t;

  // Smallest of the three neighbours plus one, capped at the widest size.
  function automatic size_t grow_size(input size_t up, input size_t left,
                                      input size_t diag);
    size_t           m;
    logic [SIZE_W:0] s;
    m = (up < left) ? up : left;
    m = (m < diag) ? m : diag;
    s = {1'b0, m} + {{SIZE_W{1'b0}}, 1'b1};
    if (s > {1'b0, SIZE_CAP}) begin
      grow_size = SIZE_CAP;
    end else begin
      grow_size = s[SIZE_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/largest_free_square_finder.sv =====
// ----------------------------------------------------------------------------
// largest_free_square_finder
// Streams a character grid and reports the largest all-free square.
// ----------------------------------------------------------------------------
// Send the grid one cell per item in row-major order, marking the last cell
// of each row on in_tuser and the last cell of the grid on in_tlast (which
// also ends its row). A cell whose character equals the configured free code
// is free. The block takes one item per clock: the item is accepted and the
// row buffer entry above it is read, and in the compute stage its square size,
// min(up, left, diagonal) + 1, is formed and written back, so the single
// read port and single write port of the row buffer set the rate. A result
// item is loaded into the output register when the end-of-grid cell leaves
// the compute stage and holds there until taken; input stalls only while a
// second end-of-grid cell waits behind an untaken result. Ties keep the
// first square found. Cells beyond MAX_COLS columns or MAX_ROWS rows are
// dropped and flag too_large. Write the free code only while the block is
// idle; it needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module largest_free_square_finder #(
  parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration: free_code
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfsf_pkg::CHAR_W-1:0]        cfg_data,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lfsf_pkg::CHAR_W-1:0]        in_tdata,  // [7:0] cell_char
  input  logic                               in_tlast,  // end_of_map
  input  logic [0:0]                         in_tuser,  // [0] end_of_row
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lfsf_pkg::OUT_DATA_W-1:0]    out_tdata, // [10:0] best_size,
                                                        // [20:11] best_row,
                                                        // [30:21] best_col,
                                                        // [31] zero
  output logic [0:0]                         out_tuser  // [0] too_large
);
  import lfsf_pkg::*;

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam logic [CW-1:0] COL_LIM = CW'(MAX_COLS);
  localparam logic [RW-1:0] ROW_LIM = RW'(MAX_ROWS);

  // configuration
  logic [CHAR_W-1:0] free_code_r;

  // accept-side counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] upper_len_r, upper_len_nxt;

  // compute stage
  logic          s1_valid_r;
  logic          s1_free_r;
  logic          s1_eor_r;
  logic          s1_eom_r;
  logic          s1_active_r;
  logic          s1_upv_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;

  // grid state
  size_t         left_r, left_nxt;
  size_t         diag_r, diag_nxt;
  size_t         largest_size_r, largest_size_nxt;
  logic [RW-1:0] largest_row_r, largest_row_nxt;
  logic [CW-1:0] largest_col_r, largest_col_nxt;
  logic          ovf_r, ovf_nxt;

  // result register
  logic          out_valid_r;
  size_t         out_size_r;
  logic [POS_W-1:0] out_row_r;
  logic [POS_W-1:0] out_col_r;
  logic          out_ovf_r;

  logic          advance;
  logic          in_fire;
  logic          s1_fire;
  logic          in_active;
  logic          row_end;
  logic [CW-1:0] col_inc;
  size_t         up_raw;
  size_t         up_eff;
  size_t         size_c;

  // Stall only when an end-of-grid item would overwrite an untaken result.
  assign advance   = !(s1_valid_r && s1_eom_r && out_valid_r && !out_tready);
  assign in_tready = advance;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && advance;
  assign s1_fire   = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_code_r <= FREE_CODE_RST;
    end else if (cfg_valid) begin
      free_code_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- accept
  assign in_active = (col_r < COL_LIM) && (row_r < ROW_LIM);
  assign row_end   = in_tuser[0] || in_tlast;
  assign col_inc   = (col_r < COL_LIM) ? col_r + CW'(1) : col_r;

  always_comb begin
    col_nxt       = col_inc;
    row_nxt       = row_r;
    upper_len_nxt = upper_len_r;
    if (row_end) begin
      col_nxt       = '0;
      upper_len_nxt = col_inc;
      row_nxt       = (row_r < ROW_LIM) ? row_r + RW'(1) : row_r;
    end
    // a fresh grid starts after the last cell
    if (in_tlast) begin
      row_nxt       = '0;
      upper_len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      upper_len_r <= '0;
      s1_valid_r  <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_tvalid;
      if (in_tvalid) begin
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        upper_len_r <= upper_len_nxt;
      end
    end
  end

  // Hold the item's fields for the compute stage.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_free_r   <= (in_tdata == free_code_r);
      s1_eor_r    <= in_tuser[0];
      s1_eom_r    <= in_tlast;
      s1_active_r <= in_active;
      s1_upv_r    <= (col_r < upper_len_r);
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
    end
  end

  lfsf_line_buf #(
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .rd_en   (in_tvalid && in_active),
    .rd_addr (col_r[AW-1:0]),
    .wr_en   (s1_fire && s1_active_r),
    .wr_addr (s1_col_r[AW-1:0]),
    .wr_data (size_c),
    .rd_data (up_raw)
  );

  // --------------------------------------------------------------- compute
  // Columns past the previous row's end, and the first row, see up as zero.
  assign up_eff = s1_upv_r ? up_raw : '0;
  assign size_c = s1_free_r ? grow_size(up_eff, left_r, diag_r) : '0;

  always_comb begin
    left_nxt         = left_r;
    diag_nxt         = diag_r;
    largest_size_nxt = largest_size_r;
    largest_row_nxt  = largest_row_r;
    largest_col_nxt  = largest_col_r;
    ovf_nxt          = ovf_r || !s1_active_r;
    if (s1_active_r) begin
      left_nxt = size_c;
      diag_nxt = up_eff;
      // strictly larger only, so the first square found keeps a tie
      if (size_c > largest_size_r) begin
        largest_size_nxt = size_c;
        largest_row_nxt  = s1_row_r;
        largest_col_nxt  = s1_col_r;
      end
    end
    if (s1_eor_r || s1_eom_r) begin
      left_nxt = '0;
      diag_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r         <= '0;
      diag_r         <= '0;
      largest_size_r <= '0;
      largest_row_r  <= '0;
      largest_col_r  <= '0;
      ovf_r          <= 1'b0;
    end else if (s1_fire) begin
      left_r <= left_nxt;
      diag_r <= diag_nxt;
      if (s1_eom_r) begin
        largest_size_r <= '0;
        largest_row_r  <= '0;
        largest_col_r  <= '0;
        ovf_r          <= 1'b0;
      end else begin
        largest_size_r <= largest_size_nxt;
        largest_row_r  <= largest_row_nxt;
        largest_col_r  <= largest_col_nxt;
        ovf_r          <= ovf_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_eom_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_eom_r) begin
      out_size_r <= largest_size_nxt;
      out_row_r  <= POS_W'(largest_row_nxt);
      out_col_r  <= POS_W'(largest_col_nxt);
      out_ovf_r  <= ovf_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {1'b0, out_col_r, out_row_r, out_size_r};
  assign out_tuser[0] = out_ovf_r;

`ifndef SYNTHESIS
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_eom_r |=> out_valid_r)
    else $error("end-of-grid item produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && !out_tready && s1_valid_r && s1_eom_r)
    else $error("input stalled without a waiting result");

  a_grid_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> col_r == '0 && row_r == '0 && upper_len_r == '0)
    else $error("counters not cleared after end of grid");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_size_r == '0 |-> out_row_r == '0 && out_col_r == '0)
    else $error("empty result carries a position");
`endif

endmodule

// ===== hdl/lfsf_line_buf.sv =====
// ----------------------------------------------------------------------------
// lfsf_line_buf
// Row buffer of square sizes: one write and one registered read per cycle,
// with the write forwarded when it hits the entry being read.
// ----------------------------------------------------------------------------
module lfsf_line_buf #(
  parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
  parameter int AW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  lfsf_pkg::size_t       wr_data,
  output lfsf_pkg::size_t       rd_data
);
  import lfsf_pkg::*;

  size_t mem [MAX_COLS];
  size_t rd_q_r;
  size_t fwd_val_r;
  logic  fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en && rd_en) begin
      rd_q_r    <= mem[rd_addr];
      fwd_val_r <= wr_data;
    end
  end

  // Same entry written this cycle: take the new value, not the stale one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (en && rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_val_r : rd_q_r;

endmodule

// ===== verif/tb_largest_free_square_finder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_largest_free_square_finder
// Streams character grids into the square finder and checks every reported
// square against a behavioural model of the row-buffer dynamic program.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [lfsf_pkg::SIZE_W-1:0] size;
  logic [lfsf_pkg::POS_W-1:0]  row;
  logic [lfsf_pkg::POS_W-1:0]  col;
  logic                        too_large;
} square_report_t;

// Tracks the square sizes of the grid being streamed and holds the reports
// still owed by the block.
class square_scoreboard;
  localparam int unsigned COLS_LIMIT = lfsf_pkg::MAX_COLS_DEF;
  localparam int unsigned ROWS_LIMIT = lfsf_pkg::MAX_ROWS_DEF;
  localparam int unsigned SIZE_LIMIT = 2047;

  logic [lfsf_pkg::CHAR_W-1:0] free_char;
  int unsigned    sizes_above [COLS_LIMIT];
  int unsigned    above_len;
  int unsigned    left_sz;
  int unsigned    diag_sz;
  int unsigned    col;
  int unsigned    row;
  int unsigned    best_size;
  int unsigned    best_row;
  int unsigned    best_col;
  bit             overflow;
  square_report_t owed_reports [$];
  int             errors;

  function new();
    free_char = lfsf_pkg::FREE_CODE_RST;
    errors    = 0;
    clear_grid();
  endfunction

  function void clear_grid();
    foreach (sizes_above[i]) sizes_above[i] = 0;
    above_len = 0;
    left_sz   = 0;
    diag_sz   = 0;
    col       = 0;
    row       = 0;
    best_size = 0;
    best_row  = 0;
    best_col  = 0;
    overflow  = 1'b0;
  endfunction

  // Advance the grid by one accepted cell; owe a report on the end-of-map cell.
  function void note_cell(logic [lfsf_pkg::CHAR_W-1:0] ch, bit eor, bit eom);
    int unsigned    up;
    int unsigned    sz;
    square_report_t rep;
    if (col >= COLS_LIMIT || row >= ROWS_LIMIT) begin
      overflow = 1'b1;
    end else begin
      up = (col < above_len) ? sizes_above[col] : 0;
      sz = 0;
      if (ch == free_char) begin
        sz = up;
        if (left_sz < sz) sz = left_sz;
        if (diag_sz < sz) sz = diag_sz;
        sz = sz + 1;
        if (sz > SIZE_LIMIT) sz = SIZE_LIMIT;
      end
      sizes_above[col] = sz;
      diag_sz = up;
      left_sz = sz;
      // strictly larger only, so the first square found wins a tie
      if (sz > best_size) begin
        best_size = sz;
        best_row  = row;
        best_col  = col;
      end
    end
    if (col < COLS_LIMIT) col = col + 1;
    if (eor || eom) begin
      above_len = col;
      col       = 0;
      left_sz   = 0;
      diag_sz   = 0;
      if (row < ROWS_LIMIT) row = row + 1;
    end
    if (eom) begin
      rep.size      = best_size[lfsf_pkg::SIZE_W-1:0];
      rep.row       = best_row[lfsf_pkg::POS_W-1:0];
      rep.col       = best_col[lfsf_pkg::POS_W-1:0];
      rep.too_large = overflow;
      owed_reports.push_back(rep);
      clear_grid();
    end
  endfunction

  function void compare(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [lfsf_pkg::OUT_DATA_W-1:0] data, logic [0:0] user);
    square_report_t want;
    if (owed_reports.size() == 0) begin
      $error("result item with no report owed: tdata %0h, tuser %0d", data, user);
      errors++;
    end else begin
      want = owed_reports.pop_front();
      compare("best_size", want.size, data[10:0]);
      compare("best_row", want.row, data[20:11]);
      compare("best_col", want.col, data[30:21]);
      compare("tdata padding", 0, data[31]);
      compare("too_large", want.too_large, user[0]);
    end
  endfunction
endclass

module tb_largest_free_square_finder;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
  localparam int OVERFLOW_LEN   = 1030;  // just past both grid limits

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [lfsf_pkg::CHAR_W-1:0]       cfg_data = '0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [lfsf_pkg::CHAR_W-1:0]       in_tdata = '0;   // [7:0] cell_char
  logic                              in_tlast = 1'b0; // end_of_map
  logic [0:0]                        in_tuser = '0;   // [0] end_of_row
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [lfsf_pkg::OUT_DATA_W-1:0]   out_tdata;       // [10:0] best_size,
                                                      // [20:11] best_row,
                                                      // [30:21] best_col,
                                                      // [31] zero
  logic [0:0]                        out_tuser;       // [0] too_large

  square_scoreboard               sb = new();
  logic [lfsf_pkg::CHAR_W-1:0]    cur_free = lfsf_pkg::FREE_CODE_RST;
  int                             tx_idle_pct = 0;
  int                             rx_stall_pct = 0;
  int                             cells_sent = 0;
  int                             quiet_cycles = 0;

  largest_free_square_finder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Receiver: stall at random at the rate set for the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Monitor: every handshake is sampled on the edge that completes it, so the
  // model sees writes, cells and results in the same order as the block does.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.free_char = cfg_data;
      if (in_tvalid && in_tready) sb.note_cell(in_tdata, in_tuser[0], in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // Watchdog: count cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
        (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one cell and hold it until taken. The valid is left high so that a
  // following cell streams back to back; a gap lowers it first.
  task automatic send_cell(input logic [7:0] ch, input bit eor, input bit eom);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= ch;
    in_tuser[0] <= eor;
    in_tlast    <= eom;
    do @(posedge clk); while (!in_tready);
    cells_sent++;
  endtask

  // Send a text row; the last character closes the row and, if asked, the map.
  task automatic send_text_row(input string s, input bit eor, input bit eom);
    for (int i = 0; i < s.len(); i++) begin
      send_cell(s[i], (i == s.len() - 1) && eor, (i == s.len() - 1) && eom);
    end
  endtask

  // Drop the valid and wait until every report owed has come back, then let
  // the pipeline settle so that no cell is still in flight. The first edge
  // lets the monitor note the last accepted cell before the queue is read.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_free_code(input logic [7:0] code);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_free = code;
  endtask

  // Well-formed map with random content: mostly rectangular, some ragged rows,
  // the final cell with or without its own end-of-row mark.
  task automatic send_map();
    int wmax;
    int w;
    int h;
    int len;
    int pct;
    bit last;
    wmax = ($urandom_range(9) == 0) ? 24 : 8;
    w    = $urandom_range(wmax, 1);
    h    = $urandom_range(wmax, 1);
    pct  = $urandom_range(95, 40);
    for (int r = 0; r < h; r++) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(wmax, 1) : w;
      for (int c = 0; c < len; c++) begin
        last = (r == h - 1) && (c == len - 1);
        send_cell(($urandom_range(99) < pct) ? cur_free : 8'($urandom),
                  (c == len - 1) && (!last || $urandom_range(1)), last);
      end
    end
  endtask

  // Broken map: row ends fall anywhere; the run still closes with an end of map.
  task automatic send_noise();
    int n;
    n = $urandom_range(30, 1);
    for (int i = 0; i < n; i++) begin
      send_cell($urandom_range(1) ? cur_free : 8'($urandom),
                $urandom_range(3) == 0, i == n - 1);
    end
  endtask

  // One phase: settle, change the free code, then stream random maps with
  // an occasional full pause until the owed reports have all come back.
  task automatic run_phase(input int tx_pct, input int rx_pct, input logic [7:0] code,
                           input int target);
    int maps;
    int start;
    maps  = 0;
    start = cells_sent;
    drain();
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    write_free_code(code);
    while (cells_sent - start < target || maps < 20) begin
      if ($urandom_range(99) < 15) begin
        send_noise();
      end else begin
        send_map();
      end
      maps++;
      if ($urandom_range(7) == 0) drain();
    end
  endtask

  // Grid past the limits. Wide: one row overruns the columns, the only
  // in-range free cell sits in the last legal column, then a short row.
  // Tall: single-cell rows overrun the rows, the only in-range free cell sits
  // in the last legal row. Cells beyond the limits are free but must be dropped.
  task automatic send_overflow_map(input bit wide);
    logic [7:0] ch;
    for (int i = 0; i < OVERFLOW_LEN; i++) begin
      ch = (i >= 1023) ? cur_free : ~cur_free;
      send_cell(ch, wide ? (i == OVERFLOW_LEN - 1) : 1'b1, !wide && (i == OVERFLOW_LEN - 1));
    end
    if (wide) begin
      send_cell(cur_free, 1'b0, 1'b0);
      send_cell(cur_free, 1'b0, 1'b0);
      send_cell(cur_free, 1'b0, 1'b1);
    end
  endtask

  initial begin
    tx_idle_pct  = 15;
    rx_stall_pct = 60;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed maps under the reset free code '.':
    // a lone free cell closed by end of map alone, a lone obstacle 0xFF,
    send_cell(8'h2E, 1'b0, 1'b1);
    send_cell(8'hFF, 1'b1, 1'b1);
    // a 2x2 square touching the right and bottom edges,
    send_text_row("..", 1'b1, 1'b0);
    send_text_row("..", 1'b1, 1'b1);
    // ragged rows where the longer row sees nothing above its tail,
    send_text_row(".", 1'b1, 1'b0);
    send_text_row("...", 1'b1, 1'b0);
    send_text_row("...", 1'b0, 1'b1);
    // and two equal squares where the first must be kept.
    send_text_row("..x..", 1'b1, 1'b0);
    send_text_row("..x..", 1'b1, 1'b1);

    // Random phases at the free code extremes and one in between.
    run_phase(15, 60, 8'h00, 350);
    run_phase(60, 15, 8'hFF, 350);
    run_phase(0, 0, 8'($urandom_range(254, 1)), 350);

    // Overflow of columns and of rows, streamed with no idling.
    send_overflow_map(1'b1);
    send_overflow_map(1'b0);

    drain();
    if (sb.errors == 0 && sb.owed_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
